>>> src/aioc_pkg.sv
`default_nettype none

package aioc_pkg;

   // bus access kinds
   localparam logic [1:0] ACT_CMD_WRITE  = 2'd0;
   localparam logic [1:0] ACT_CMD_READ   = 2'd1;
   localparam logic [1:0] ACT_DATA_WRITE = 2'd2;
   localparam logic [1:0] ACT_DATA_READ  = 2'd3;

   // command bytes
   localparam logic [7:0] CMD_CANCEL = 8'h10;
   localparam logic [7:0] CMD_SWITCH = 8'ha1;
   localparam logic [7:0] CMD_CREDIT = 8'he1;
   localparam logic [7:0] CMD_READ_A = 8'h71;
   localparam logic [7:0] CMD_READ_B = 8'hb1;
   localparam logic [7:0] CMD_SOUND  = 8'ha8;

   // data register offsets
   localparam logic [3:0] OFF_SYSTEM  = 4'd0;
   localparam logic [3:0] OFF_PLAYER1 = 4'd1;
   localparam logic [3:0] OFF_PLAYER2 = 4'd2;
   localparam logic [3:0] OFF_SOUND   = 4'd3;
   localparam logic [3:0] OFF_RATE    = 4'd7;

   // system port bits, active low
   localparam logic [7:0] COIN_MASK  = 8'h70;
   localparam int         START1_BIT = 2;
   localparam int         START2_BIT = 3;

   localparam logic [6:0] CREDIT_MAX        = 7'd99;
   localparam logic [6:0] FREE_PLAY_CREDITS = 7'd2;
   localparam logic [7:0] READ_UNMATCHED    = 8'hff;

   // sound data bytes and request codes
   localparam logic [7:0] SND_DATA_SAMPLE1 = 8'h02;
   localparam logic [7:0] SND_DATA_SAMPLE0 = 8'h20;
   localparam logic [1:0] SND_NONE         = 2'd0;
   localparam logic [1:0] SND_SAMPLE0      = 2'd1;
   localparam logic [1:0] SND_SAMPLE1      = 2'd2;

   typedef struct packed {
      logic [1:0] action;
      logic [3:0] reg_offset;
      logic [7:0] write_data;
      logic [7:0] system_port;
      logic [7:0] player1_port;
      logic [7:0] player2_port;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       nmi_arm;
      logic       nmi_cancel;
      logic [1:0] sound_request;
   } rsp_type;

   // handshake between input stage and downstream
   typedef struct packed {
      logic take;   // downstream can absorb a beat this cycle
      logic fire;   // held beat moves on this cycle
   } stage_ctl_type;

endpackage

`default_nettype wire

>>> src/aioc_req_stage.sv
`default_nettype none

module aioc_req_stage
   import aioc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_in,
   input  wire logic    take,
   output stage_ctl_type ctl,
   output req_type      req_out
);

   logic    valid_ff, valid_in;
   req_type data_ff;

   assign req_ready = !valid_ff || take;
   assign ctl.take  = take;
   assign ctl.fire  = valid_ff && take;
   assign valid_in  = req_ready ? req_valid : valid_ff;
   assign req_out   = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         data_ff <= req_in;
      end
   end

endmodule

`default_nettype wire

>>> src/aioc_exec.sv
`default_nettype none

module aioc_exec
   import aioc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire stage_ctl_type ctl,
   input  wire req_type       req,
   output rsp_type            rsp
);

   logic [7:0] command_ff, command_in;
   logic       switch_ff, switch_in;
   logic [6:0] credit_ff, credit_in;
   logic [7:0] tally_ff, tally_in;
   logic [7:0] cpc_ff, cpc_in;       // coins per credit
   logic [7:0] crpc_ff, crpc_in;     // credits per coin
   logic [7:0] store1_ff, store1_in; // only entries 1 and 2 are ever read back
   logic [7:0] store2_ff, store2_in;
   logic       armed_ff, armed_in;

   logic       cmd_read_ok;
   logic [7:0] tally_inc;
   logic [8:0] sum;
   logic [6:0] cr_coin, cr_s1, cr_fin;
   logic [7:0] credit_bcd;
   logic [14:0] tens_prod;
   logic [3:0] tens;
   logic [6:0] tens_x10, ones;

   assign cmd_read_ok = (command_ff == CMD_READ_A) || (command_ff == CMD_READ_B);
   assign tally_inc   = tally_ff + 8'd1;
   assign sum         = {2'b00, credit_ff} + {1'b0, crpc_ff};

   // credit-mode read path: coin or free play, saturate, start buttons
   always_comb begin
      cr_coin = credit_ff;
      tally_in = tally_ff;
      if (cpc_ff != 8'd0) begin
         if (((req.system_port & COIN_MASK) != COIN_MASK) && (credit_ff < CREDIT_MAX)) begin
            tally_in = tally_inc;
            if (tally_inc >= cpc_ff) begin
               cr_coin  = (sum > {2'b00, CREDIT_MAX}) ? CREDIT_MAX : sum[6:0];
               tally_in = 8'd0;
            end
         end
      end else begin
         cr_coin = FREE_PLAY_CREDITS;
      end
      cr_s1 = (!req.system_port[START1_BIT] && cr_coin >= 7'd1) ? cr_coin - 7'd1 : cr_coin;
      cr_fin = (!req.system_port[START2_BIT] && cr_s1 >= 7'd2) ? cr_s1 - 7'd2 : cr_s1;
   end

   // divide by ten through the reciprocal, exact below 100
   assign tens_prod  = {8'd0, cr_fin} * 15'd205;
   assign tens       = tens_prod[14:11];
   assign tens_x10   = {tens, 3'b000} + {2'b00, tens, 1'b0};
   assign ones       = cr_fin - tens_x10;
   assign credit_bcd = {tens, ones[3:0]};

   always_comb begin
      command_in = command_ff;
      switch_in  = switch_ff;
      credit_in  = credit_ff;
      cpc_in     = cpc_ff;
      crpc_in    = crpc_ff;
      store1_in  = store1_ff;
      store2_in  = store2_ff;
      armed_in   = armed_ff;
      rsp        = '0;
      unique case (req.action)
         ACT_CMD_WRITE: begin
            command_in = req.write_data;
            if (req.write_data == CMD_CANCEL) begin
               rsp.nmi_cancel = armed_ff;
               armed_in = 1'b0;
            end else begin
               if (req.write_data == CMD_SWITCH) begin
                  switch_in = 1'b1;
               end else if (req.write_data == CMD_CREDIT) begin
                  credit_in = 7'd0;
                  switch_in = 1'b0;
               end
               armed_in    = 1'b1;
               rsp.nmi_arm = 1'b1;
            end
         end
         ACT_CMD_READ: begin
            rsp.read_data = command_ff;
         end
         ACT_DATA_WRITE: begin
            if (req.reg_offset == OFF_PLAYER1) store1_in = req.write_data;
            if (req.reg_offset == OFF_PLAYER2) store2_in = req.write_data;
            if (command_ff == CMD_SOUND && req.reg_offset == OFF_SOUND) begin
               if (req.write_data == SND_DATA_SAMPLE1) begin
                  rsp.sound_request = SND_SAMPLE1;
               end else if (req.write_data == SND_DATA_SAMPLE0) begin
                  rsp.sound_request = SND_SAMPLE0;
               end else begin
                  rsp.sound_request = SND_NONE;
               end
            end else if (command_ff == CMD_CREDIT && req.reg_offset == OFF_RATE) begin
               cpc_in  = store1_ff;
               crpc_in = store2_ff;
            end
         end
         ACT_DATA_READ: begin
            rsp.read_data = READ_UNMATCHED;
            if (cmd_read_ok) begin
               if (req.reg_offset == OFF_SYSTEM) begin
                  if (switch_ff) begin
                     rsp.read_data = req.system_port;
                  end else begin
                     rsp.read_data = credit_bcd;
                     credit_in     = cr_fin;
                  end
               end else if (req.reg_offset == OFF_PLAYER1) begin
                  rsp.read_data = req.player1_port;
               end else if (req.reg_offset == OFF_PLAYER2) begin
                  rsp.read_data = req.player2_port;
               end
            end
         end
         default: begin
            rsp = '0;
         end
      endcase
   end

   // tally only moves on a credit-mode system read
   logic credit_read;
   assign credit_read = (req.action == ACT_DATA_READ) && cmd_read_ok &&
                        (req.reg_offset == OFF_SYSTEM) && !switch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         command_ff <= '0;
         switch_ff  <= 1'b0;
         credit_ff  <= '0;
         tally_ff   <= '0;
         cpc_ff     <= '0;
         crpc_ff    <= '0;
         store1_ff  <= '0;
         store2_ff  <= '0;
         armed_ff   <= 1'b0;
      end else if (ctl.fire) begin
         command_ff <= command_in;
         switch_ff  <= switch_in;
         credit_ff  <= credit_in;
         if (credit_read) tally_ff <= tally_in;
         cpc_ff     <= cpc_in;
         crpc_ff    <= crpc_in;
         store1_ff  <= store1_in;
         store2_ff  <= store2_in;
         armed_ff   <= armed_in;
      end
   end

endmodule

`default_nettype wire

>>> src/arcade_io_credit_controller.sv
// A request beat accepted into the input register moves on into the response register.
// One beat per cycle unless stalled; input register, execute logic, response register.
// Backpressure on rsp_ready stalls the pipeline without losing or repeating beats.
// Reset (synchronous, active high) clears command, mode, credits, coin tally, rates,
// data store, NMI arm state and both valid flags.
`default_nettype none

module arcade_io_credit_controller
   import aioc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_action,
   input  wire logic [3:0] req_reg_offset,
   input  wire logic [7:0] req_write_data,
   input  wire logic [7:0] req_system_port,
   input  wire logic [7:0] req_player1_port,
   input  wire logic [7:0] req_player2_port,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_read_data,
   output logic            rsp_nmi_arm,
   output logic            rsp_nmi_cancel,
   output logic [1:0]      rsp_sound_request
);

   req_type       req_in, req_held;
   rsp_type       rsp_next, rsp_ff;
   stage_ctl_type ctl;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign req_in = '{action:       req_action,
                     reg_offset:   req_reg_offset,
                     write_data:   req_write_data,
                     system_port:  req_system_port,
                     player1_port: req_player1_port,
                     player2_port: req_player2_port};

   // response register is free when empty or draining this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   aioc_req_stage u_req_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_in    (req_in),
      .take      (out_free),
      .ctl       (ctl),
      .req_out   (req_held)
   );

   // state updates happen on the same edge the held beat moves into the response register
   aioc_exec u_exec (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .req   (req_held),
      .rsp   (rsp_next)
   );

   assign rsp_valid_in = ctl.fire ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fire) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_ff.read_data;
   assign rsp_nmi_arm       = rsp_ff.nmi_arm;
   assign rsp_nmi_cancel    = rsp_ff.nmi_cancel;
   assign rsp_sound_request = rsp_ff.sound_request;

endmodule

`default_nettype wire

>>> src/aioc_checker.sv
`default_nettype none

module aioc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_read_data,
   input wire logic       rsp_nmi_arm,
   input wire logic       rsp_nmi_cancel,
   input wire logic [1:0] rsp_sound_request
);

   // response beat holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) &&
      $stable(rsp_sound_request))
      else $error("response beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_arm_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_nmi_arm && rsp_nmi_cancel))
      else $error("NMI arm and cancel in one beat");

   // only a read returns data; sound and NMI flags come from writes
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_nmi_arm || rsp_nmi_cancel || rsp_sound_request != 2'd0) |->
      rsp_read_data == 8'd0)
      else $error("write beat returned read data");

   // an idle pipeline always takes a request
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && req_ready) |=> req_ready)
      else $error("input stalled with empty pipeline");

endmodule

bind arcade_io_credit_controller aioc_checker u_aioc_checker (.*);

`default_nettype wire

>>> sim/tb_arcade_io_credit_controller.sv
`timescale 1ns / 1ps

module tb_arcade_io_credit_controller;
   import aioc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before we call it hung
   localparam int HOLD_CYCLES    = 60;    // long rsp_ready hold-off for the pressure phase
   localparam int DRAIN_CYCLES   = 8;     // pipe is 2 deep, leave some margin
   localparam int PHASE_BEATS    = 130;
   localparam int PRESSURE_BEATS = 30;

   // store slots picked up by the rate latch
   localparam logic [3:0] STORE_COINS   = 4'd1;
   localparam logic [3:0] STORE_CREDITS = 4'd2;
   localparam logic [3:0] OFF_LAST      = 4'hf;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_action;
   logic [3:0] req_reg_offset;
   logic [7:0] req_write_data;
   logic [7:0] req_system_port;
   logic [7:0] req_player1_port;
   logic [7:0] req_player2_port;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_read_data;
   logic       rsp_nmi_arm;
   logic       rsp_nmi_cancel;
   logic [1:0] rsp_sound_request;

   arcade_io_credit_controller u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_reg_offset    (req_reg_offset),
      .req_write_data    (req_write_data),
      .req_system_port   (req_system_port),
      .req_player1_port  (req_player1_port),
      .req_player2_port  (req_player2_port),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_data     (rsp_read_data),
      .rsp_nmi_arm       (rsp_nmi_arm),
      .rsp_nmi_cancel    (rsp_nmi_cancel),
      .rsp_sound_request (rsp_sound_request)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Shadow copy of the chip state, advanced once per accepted beat
   // ---------------------------------------------------------------
   logic [7:0] mdl_command;
   logic       mdl_switch;
   logic [6:0] mdl_credits;
   logic [7:0] mdl_tally;
   logic [7:0] mdl_coins_per_credit;
   logic [7:0] mdl_credits_per_coin;
   logic [7:0] mdl_store [16];
   logic       mdl_armed;

   rsp_type pending_bus_rsp [$];  // responses owed by the DUT, oldest first
   int      bus_beats_sent;
   int      rsp_errors;

   // knobs for the driver and the response sink
   int src_idle_pct;
   int sink_stall_pct;
   bit hold_request;

   function automatic rsp_type io_chip_predict(input req_type r);
      rsp_type o;
      int      cr;
      o = '0;
      case (r.action)
         ACT_CMD_WRITE: begin
            mdl_command = r.write_data;
            if (r.write_data == CMD_CANCEL) begin
               // cancel only reports when a timer was actually running
               o.nmi_cancel = mdl_armed;
               mdl_armed = 1'b0;
            end else begin
               if (r.write_data == CMD_SWITCH) begin
                  mdl_switch = 1'b1;
               end else if (r.write_data == CMD_CREDIT) begin
                  mdl_credits = '0;
                  mdl_switch = 1'b0;
               end
               mdl_armed = 1'b1;
               o.nmi_arm = 1'b1;
            end
         end
         ACT_CMD_READ: o.read_data = mdl_command;
         ACT_DATA_WRITE: begin
            mdl_store[r.reg_offset] = r.write_data;
            if (mdl_command == CMD_SOUND && r.reg_offset == OFF_SOUND) begin
               if (r.write_data == SND_DATA_SAMPLE1) o.sound_request = SND_SAMPLE1;
               else if (r.write_data == SND_DATA_SAMPLE0) o.sound_request = SND_SAMPLE0;
            end else if (mdl_command == CMD_CREDIT && r.reg_offset == OFF_RATE) begin
               mdl_coins_per_credit = mdl_store[STORE_COINS];
               mdl_credits_per_coin = mdl_store[STORE_CREDITS];
            end
         end
         default: begin
            o.read_data = READ_UNMATCHED;
            if (mdl_command == CMD_READ_A || mdl_command == CMD_READ_B) begin
               if (r.reg_offset == OFF_SYSTEM) begin
                  if (mdl_switch) begin
                     o.read_data = r.system_port;
                  end else begin
                     cr = int'(mdl_credits);
                     if (mdl_coins_per_credit != 8'd0) begin
                        // any coin low counts, unless already full
                        if ((r.system_port & COIN_MASK) != COIN_MASK && cr < 99) begin
                           mdl_tally = mdl_tally + 8'd1;
                           if (mdl_tally >= mdl_coins_per_credit) begin
                              cr = cr + int'(mdl_credits_per_coin);
                              if (cr > 99) cr = 99;
                              mdl_tally = '0;
                           end
                        end
                     end else begin
                        cr = int'(FREE_PLAY_CREDITS);
                     end
                     if (!r.system_port[START1_BIT] && cr >= 1) cr = cr - 1;
                     if (!r.system_port[START2_BIT] && cr >= 2) cr = cr - 2;
                     mdl_credits = 7'(cr);
                     o.read_data = 8'((cr / 10) * 16 + (cr % 10));  // BCD
                  end
               end else if (r.reg_offset == OFF_PLAYER1) begin
                  o.read_data = r.player1_port;
               end else if (r.reg_offset == OFF_PLAYER2) begin
                  o.read_data = r.player2_port;
               end
            end
         end
      endcase
      return o;
   endfunction

   // random ports; system port mostly keeps the coins released so credits move slowly
   function automatic req_type shape_access(input logic [1:0] act, input logic [3:0] off,
                                            input logic [7:0] wd);
      req_type r;
      r.action       = act;
      r.reg_offset   = off;
      r.write_data   = wd;
      r.system_port  = 8'($urandom);
      r.player1_port = 8'($urandom);
      r.player2_port = 8'($urandom);
      if ($urandom_range(0, 2) != 0) r.system_port = r.system_port | COIN_MASK;
      if ($urandom_range(0, 1) != 0) r.system_port[START2_BIT:START1_BIT] = 2'b11;
      return r;
   endfunction

   // Present one beat. Entered at a posedge (or right after reset), returns at the
   // posedge that took the beat. Valid is only ever written once per negedge.
   task automatic send_beat(input req_type r, input bit typed, input rsp_type want);
      rsp_type due;
      @(negedge clock);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= r.action;
      req_reg_offset   <= r.reg_offset;
      req_write_data   <= r.write_data;
      req_system_port  <= r.system_port;
      req_player1_port <= r.player1_port;
      req_player2_port <= r.player2_port;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // shadow state always advances; hand-typed rows override the prediction
      due = io_chip_predict(r);
      if (typed) due = want;
      pending_bus_rsp.push_back(due);
      bus_beats_sent++;
   endtask

   // well-formed command/data sequences with random content, plus some noise
   task automatic run_traffic(input int n);
      int         stop_at;
      int         k;
      logic [7:0] wd;
      stop_at = bus_beats_sent + n;
      while (bus_beats_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               // credit mode plus a fresh coin rate
               send_beat(shape_access(ACT_CMD_WRITE, 4'($urandom), CMD_CREDIT), 1'b0, '0);
               wd = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
               send_beat(shape_access(ACT_DATA_WRITE, STORE_COINS, wd), 1'b0, '0);
               wd = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 5));
               send_beat(shape_access(ACT_DATA_WRITE, STORE_CREDITS, wd), 1'b0, '0);
               send_beat(shape_access(ACT_DATA_WRITE, OFF_RATE, 8'($urandom)), 1'b0, '0);
            end
            2, 3, 4, 5: begin
               wd = $urandom_range(0, 1) ? CMD_READ_A : CMD_READ_B;
               send_beat(shape_access(ACT_CMD_WRITE, 4'($urandom), wd), 1'b0, '0);
               k = $urandom_range(3, 8);
               repeat (k) begin
                  send_beat(shape_access(ACT_DATA_READ,
                                         ($urandom_range(0, 5) == 0) ? 4'($urandom)
                                                                     : 4'($urandom_range(0, 2)),
                                         8'($urandom)), 1'b0, '0);
               end
            end
            6: begin
               send_beat(shape_access(ACT_CMD_WRITE, 4'($urandom), CMD_SOUND), 1'b0, '0);
               k = $urandom_range(1, 4);
               repeat (k) begin
                  case ($urandom_range(0, 2))
                     0:       wd = SND_DATA_SAMPLE1;
                     1:       wd = SND_DATA_SAMPLE0;
                     default: wd = 8'($urandom);
                  endcase
                  send_beat(shape_access(ACT_DATA_WRITE,
                                         ($urandom_range(0, 3) == 0) ? 4'($urandom) : OFF_SOUND,
                                         wd), 1'b0, '0);
               end
            end
            7: begin
               // flip between switch and credit mode, then read the system port
               wd = $urandom_range(0, 1) ? CMD_SWITCH : CMD_CREDIT;
               send_beat(shape_access(ACT_CMD_WRITE, 4'($urandom), wd), 1'b0, '0);
               send_beat(shape_access(ACT_CMD_READ, 4'($urandom), 8'($urandom)), 1'b0, '0);
               wd = $urandom_range(0, 1) ? CMD_READ_A : CMD_READ_B;
               send_beat(shape_access(ACT_CMD_WRITE, 4'($urandom), wd), 1'b0, '0);
               k = $urandom_range(2, 4);
               repeat (k) begin
                  send_beat(shape_access(ACT_DATA_READ, OFF_SYSTEM, 8'($urandom)), 1'b0, '0);
               end
            end
            default: begin
               k = $urandom_range(1, 4);
               repeat (k) begin
                  wd = ($urandom_range(0, 2) == 0) ? CMD_CANCEL : 8'($urandom);
                  send_beat(shape_access(2'($urandom), 4'($urandom), wd), 1'b0, '0);
               end
            end
         endcase
      end
   endtask

   // ---------------------------------------------------------------
   // Directed table: hand-typed response where it is obvious,
   // otherwise the predictor decides
   // ---------------------------------------------------------------
   typedef struct packed {
      req_type req;
      logic    typed;
      rsp_type rsp;
   } access_row_type;

   localparam int ROW_COUNT = 23;

   access_row_type access_table [ROW_COUNT] = '{
      // command read straight out of reset
      '{'{ACT_CMD_READ,   OFF_SYSTEM,  8'h00, 8'hff, 8'hff, 8'hff}, 1'b1,
        '{8'h00, 1'b0, 1'b0, SND_NONE}},
      // cancel with nothing armed
      '{'{ACT_CMD_WRITE,  OFF_SYSTEM,  CMD_CANCEL, 8'hff, 8'hff, 8'hff}, 1'b1,
        '{8'h00, 1'b0, 1'b0, SND_NONE}},
      '{'{ACT_CMD_WRITE,  OFF_SYSTEM,  CMD_READ_A, 8'hff, 8'hff, 8'hff}, 1'b1,
        '{8'h00, 1'b1, 1'b0, SND_NONE}},
      // free play: 2 credits, start1 takes one, start2 can't
      '{'{ACT_DATA_READ,  OFF_SYSTEM,  8'h00, 8'hf3, 8'hff, 8'hff}, 1'b1,
        '{8'h01, 1'b0, 1'b0, SND_NONE}},
      // cancel while armed
      '{'{ACT_CMD_WRITE,  OFF_SYSTEM,  CMD_CANCEL, 8'hff, 8'hff, 8'hff}, 1'b1,
        '{8'h00, 1'b0, 1'b1, SND_NONE}},
      // read under a non-read command
      '{'{ACT_DATA_READ,  OFF_SYSTEM,  8'hff, 8'h00, 8'h00, 8'h00}, 1'b1,
        '{READ_UNMATCHED, 1'b0, 1'b0, SND_NONE}},
      '{'{ACT_CMD_WRITE,  OFF_LAST,    CMD_SOUND, 8'hff, 8'hff, 8'hff}, 1'b1,
        '{8'h00, 1'b1, 1'b0, SND_NONE}},
      '{'{ACT_DATA_WRITE, OFF_SOUND,   SND_DATA_SAMPLE1, 8'hff, 8'hff, 8'hff}, 1'b1,
        '{8'h00, 1'b0, 1'b0, SND_SAMPLE1}},
      '{'{ACT_DATA_WRITE, OFF_SOUND,   SND_DATA_SAMPLE0, 8'hff, 8'hff, 8'hff}, 1'b1,
        '{8'h00, 1'b0, 1'b0, SND_SAMPLE0}},
      '{'{ACT_DATA_WRITE, OFF_SOUND,   8'h55, 8'hff, 8'hff, 8'hff}, 1'b1,
        '{8'h00, 1'b0, 1'b0, SND_NONE}},
      // credit mode, 1 coin -> 255 credits, so the first coin saturates
      '{'{ACT_CMD_WRITE,  OFF_SYSTEM,  CMD_CREDIT, 8'hff, 8'hff, 8'hff}, 1'b1,
        '{8'h00, 1'b1, 1'b0, SND_NONE}},
      '{'{ACT_DATA_WRITE, STORE_COINS, 8'h01, 8'hff, 8'hff, 8'hff}, 1'b0, '0},
      '{'{ACT_DATA_WRITE, STORE_CREDITS, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, '0},
      '{'{ACT_DATA_WRITE, OFF_RATE,    8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, '0},
      '{'{ACT_CMD_WRITE,  OFF_SYSTEM,  CMD_READ_B, 8'hff, 8'hff, 8'hff}, 1'b0, '0},
      '{'{ACT_DATA_READ,  OFF_SYSTEM,  8'h00, 8'h8f, 8'hff, 8'hff}, 1'b1,
        '{8'h99, 1'b0, 1'b0, SND_NONE}},
      // full: no coin counted, both starts deduct
      '{'{ACT_DATA_READ,  OFF_SYSTEM,  8'h00, 8'h00, 8'hff, 8'hff}, 1'b1,
        '{8'h96, 1'b0, 1'b0, SND_NONE}},
      '{'{ACT_DATA_READ,  OFF_PLAYER1, 8'h00, 8'hff, 8'hff, 8'h00}, 1'b1,
        '{8'hff, 1'b0, 1'b0, SND_NONE}},
      '{'{ACT_DATA_READ,  OFF_PLAYER2, 8'h00, 8'hff, 8'h00, 8'hff}, 1'b1,
        '{8'hff, 1'b0, 1'b0, SND_NONE}},
      '{'{ACT_DATA_READ,  OFF_LAST,    8'h00, 8'hff, 8'hff, 8'hff}, 1'b1,
        '{READ_UNMATCHED, 1'b0, 1'b0, SND_NONE}},
      '{'{ACT_CMD_WRITE,  OFF_SYSTEM,  CMD_SWITCH, 8'hff, 8'hff, 8'hff}, 1'b0, '0},
      '{'{ACT_CMD_WRITE,  OFF_SYSTEM,  CMD_READ_A, 8'hff, 8'hff, 8'hff}, 1'b0, '0},
      // switch mode returns the raw port
      '{'{ACT_DATA_READ,  OFF_SYSTEM,  8'h00, 8'h5a, 8'h00, 8'h00}, 1'b1,
        '{8'h5a, 1'b0, 1'b0, SND_NONE}}
   };

   int idle_pct_tbl  [4] = '{0, 80, 0, 27};
   int stall_pct_tbl [4] = '{0, 0, 80, 27};

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   initial begin
      req_valid        = 1'b0;
      req_action       = ACT_CMD_READ;
      req_reg_offset   = '0;
      req_write_data   = '0;
      req_system_port  = '1;
      req_player1_port = '0;
      req_player2_port = '0;
      reset            = 1'b1;
      src_idle_pct     = 0;
      sink_stall_pct   = 0;
      hold_request     = 1'b0;
      bus_beats_sent   = 0;

      mdl_command          = '0;
      mdl_switch           = 1'b0;
      mdl_credits          = '0;
      mdl_tally            = '0;
      mdl_coins_per_credit = '0;
      mdl_credits_per_coin = '0;
      mdl_armed            = 1'b0;
      foreach (mdl_store[i]) mdl_store[i] = '0;

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      foreach (access_table[i]) begin
         send_beat(access_table[i].req, access_table[i].typed, access_table[i].rsp);
      end

      // pressure: sink holds off for a long stretch, sender keeps pushing
      hold_request = 1'b1;
      run_traffic(PRESSURE_BEATS);

      foreach (idle_pct_tbl[p]) begin
         src_idle_pct   = idle_pct_tbl[p];
         sink_stall_pct = stall_pct_tbl[p];
         run_traffic(PHASE_BEATS);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      src_idle_pct   = 0;
      sink_stall_pct = 0;

      while (pending_bus_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (rsp_errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // response sink; the hold-off is counted here, not in the sender
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------
   // Response check, in order against the oldest pending beat
   // ---------------------------------------------------------------
   initial rsp_errors = 0;

   always @(posedge clock) begin : rsp_check
      rsp_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_bus_rsp.size() == 0) begin
            $error("response beat with nothing pending");
            rsp_errors++;
         end else begin
            due = pending_bus_rsp.pop_front();
            if (rsp_read_data !== due.read_data) begin
               $error("read_data: expected %h, got %h", due.read_data, rsp_read_data);
               rsp_errors++;
            end
            if (rsp_nmi_arm !== due.nmi_arm) begin
               $error("nmi_arm: expected %b, got %b", due.nmi_arm, rsp_nmi_arm);
               rsp_errors++;
            end
            if (rsp_nmi_cancel !== due.nmi_cancel) begin
               $error("nmi_cancel: expected %b, got %b", due.nmi_cancel, rsp_nmi_cancel);
               rsp_errors++;
            end
            if (rsp_sound_request !== due.sound_request) begin
               $error("sound_request: expected %0d, got %0d",
                      due.sound_request, rsp_sound_request);
               rsp_errors++;
            end
         end
      end
   end

   // watchdog: too long with no beat on either channel means a hang
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

endmodule

>>> arcade_io_credit_controller.f
src/aioc_pkg.sv
src/aioc_req_stage.sv
src/aioc_exec.sv
src/arcade_io_credit_controller.sv
src/aioc_checker.sv
sim/tb_arcade_io_credit_controller.sv
